[hdl/sbt_pkg.sv]
// Package: shared types, kind codes and character helpers for the byte tokenizer.
`timescale 1ns / 1ps
package sbt_pkg;

  localparam int PosBits = 32;
  localparam int KwMaxLen = 9;
  localparam int LenBits = 4;
  localparam int KindBits = 7;
  localparam int OffBits = 32;

  typedef enum logic [4:0] {
    M_IDLE, M_OP, M_WORD, M_ZERO, M_DEC, M_FRAC, M_EXPSIGN, M_EXPDIG,
    M_BIN, M_OCT, M_HEX, M_STR, M_CHOPEN, M_CHESC, M_CHCLOSE
  } mode_t;

  typedef logic [KindBits-1:0] kind_t;

  localparam kind_t K_INT = 7'd63;
  localparam kind_t K_BIN = 7'd64;
  localparam kind_t K_HEX = 7'd65;
  localparam kind_t K_OCT = 7'd66;
  localparam kind_t K_INVALID = 7'd67;
  localparam kind_t K_REAL = 7'd77;
  localparam kind_t K_SCI = 7'd78;
  localparam kind_t K_STR = 7'd85;
  localparam kind_t K_CHAR = 7'd47;
  localparam kind_t K_ID = 7'd59;
  localparam kind_t K_EOF = 7'd53;
  localparam kind_t K_NONE = 7'd127;

  typedef struct packed {
    kind_t                kind;
    logic [OffBits-1:0]   start;
    logic [OffBits-1:0]   stop;
    logic                 last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic kind_t lone_kind(input logic [7:0] b);
    case (b)
      ".": return 7'd12;  ":": return 7'd13;  ";": return 7'd37;
      ",": return 7'd35;  "(": return 7'd31;  ")": return 7'd32;
      "{": return 7'd33;  "}": return 7'd34;  "[": return 7'd29;
      "]": return 7'd30;  "~": return 7'd23;  "|": return 7'd24;
      "#": return 7'd25;  "?": return 7'd26;  8'h5c: return 7'd27;
      "&": return 7'd28;  "^": return 7'd38;  "$": return 7'd39;
      "@": return 7'd40;
      default: return K_NONE;
    endcase
  endfunction

  function automatic kind_t op_single(input logic [7:0] b);
    case (b)
      "+": return 7'd0;   "-": return 7'd9;   "*": return 7'd14;
      "/": return 7'd16;  "%": return 7'd18;  "<": return 7'd3;
      ">": return 7'd5;   "=": return 7'd20;  "!": return 7'd7;
      default: return K_NONE;
    endcase
  endfunction

  function automatic kind_t op_pair(input logic [7:0] a, input logic [7:0] b);
    kind_t k;
    k = K_NONE;
    if (a == "+") begin
      k = (b == "=") ? 7'd1 : ((b == "+") ? 7'd2 : K_NONE);
    end else if (a == "-") begin
      k = (b == ">") ? 7'd10 : ((b == "=") ? 7'd11 : K_NONE);
    end else if (a == "=") begin
      k = (b == ">") ? 7'd21 : ((b == "=") ? 7'd22 : K_NONE);
    end else if (b == "=") begin
      case (a)
        "*": k = 7'd15;  "/": k = 7'd17;  "%": k = 7'd19;
        "<": k = 7'd4;   ">": k = 7'd6;   "!": k = 7'd8;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  // Keyword lookup on the 9-byte prefix, left-aligned, unused bytes masked.
  function automatic kind_t word_kind(input logic [KwMaxLen*8-1:0] pfx,
                                      input logic [LenBits-1:0] len);
    logic [KwMaxLen*8-1:0] w;
    kind_t k;
    w = '0;
    for (int i = 0; i < KwMaxLen; i++) begin
      if (i < int'(len)) w[(KwMaxLen-1-i)*8 +: 8] = pfx[i*8 +: 8];
    end
    k = K_ID;
    if (int'(len) <= KwMaxLen) begin
      case (w)
        {"and", 48'd0}: k = 7'd42;        {"as", 56'd0}: k = 7'd43;
        {"bool", 40'd0}: k = 7'd44;       {"break", 32'd0}: k = 7'd45;
        {"catch", 32'd0}: k = 7'd46;      {"const", 32'd0}: k = 7'd49;
        {"continue", 8'd0}: k = 7'd50;    {"else", 40'd0}: k = 7'd51;
        {"enum", 40'd0}: k = 7'd52;       {"error", 32'd0}: k = 7'd54;
        {"extern", 24'd0}: k = 7'd55;     {"false", 32'd0}: k = 7'd56;
        {"fn", 56'd0}: k = 7'd57;         {"for", 48'd0}: k = 7'd58;
        {"if", 56'd0}: k = 7'd60;         {"in", 56'd0}: k = 7'd61;
        {"inline", 24'd0}: k = 7'd62;     {"is", 56'd0}: k = 7'd68;
        {"let", 48'd0}: k = 7'd69;        {"match", 32'd0}: k = 7'd70;
        {"mod", 48'd0}: k = 7'd71;        {"newtype", 16'd0}: k = 7'd72;
        {"not", 48'd0}: k = 7'd73;        {"null", 40'd0}: k = 7'd74;
        {"or", 56'd0}: k = 7'd75;         {"private", 16'd0}: k = 7'd76;
        {"ref", 48'd0}: k = 7'd79;        {"return", 24'd0}: k = 7'd80;
        {"self", 40'd0}: k = 7'd82;       {"Self", 40'd0}: k = 7'd81;
        {"static", 24'd0}: k = 7'd84;     {"struct", 24'd0}: k = 7'd86;
        {"test", 40'd0}: k = 7'd87;       {"true", 40'd0}: k = 7'd88;
        {"typealias"}: k = 7'd89;         {"union", 32'd0}: k = 7'd90;
        {"use", 48'd0}: k = 7'd91;        {"when", 40'd0}: k = 7'd92;
        {"while", 32'd0}: k = 7'd93;
        default: k = K_ID;
      endcase
    end
    return k;
  endfunction

endpackage

[hdl/source_byte_tokenizer.sv]
// Source byte tokenizer: byte-at-a-time lexer emitting kind/offset token transfers.
//
// One source byte is taken per transfer and the block can accept a new byte every
// clock cycle. The scanner state advances in the same cycle a byte is accepted, and
// the up to three tokens that byte completes (a flushed pending token, a token of
// the byte itself, and end-of-file on a byte marked final_byte) are written into a
// four-entry result queue. Tokens leave one per cycle while out_stall is low, so
// the sustained rate is one byte per cycle while each byte yields at most one
// token; bytes that complete several tokens at once (final byte, an operator
// followed by punctuation) hold up later bytes, and in_stall rises while the queue
// lacks room for three entries. Offsets are byte positions from the start of the
// source, with end_offset one past the last byte; after the end-of-file token
// (end_of_run high) the position returns to zero for the next source.
`timescale 1ns / 1ps
module source_byte_tokenizer
  import sbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          source_byte,
  input  logic                final_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KindBits-1:0] token_kind,
  output logic [OffBits-1:0]  start_offset,
  output logic [OffBits-1:0]  end_offset,
  output logic                end_of_run
);

  localparam int QDepth = 4;
  localparam int QIdx = 2;

  // scanner state
  mode_t                  scan_mode, scan_mode_next;
  logic [PosBits-1:0]     byte_position;
  logic [PosBits-1:0]     token_start, token_start_next;
  logic [7:0]             word_prefix [KwMaxLen];
  logic [LenBits-1:0]     word_length, word_length_next;
  logic [7:0]             held_first_byte, held_first_byte_next;
  logic                   escape_pending, escape_pending_next;

  // result queue
  tok_t                   q_mem [QDepth];
  logic [QIdx-1:0]        rd_ptr, wr_ptr;
  logic [QIdx:0]          q_count;

  tok_t                   res [3];
  logic [1:0]             n_res;
  logic                   in_xfer, out_xfer;
  logic [KwMaxLen*8-1:0]  pfx_flat;
  logic                   pfx_wr;
  logic [LenBits-1:0]     pfx_idx;

  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = q_count != '0;
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = q_count > (QIdx+1)'(QDepth - 3);

  always_comb begin
    for (int i = 0; i < KwMaxLen; i++) pfx_flat[i*8 +: 8] = word_prefix[i];
  end

  // Per-byte scan: extend pending token, else start a new one, then final flush.
  always_comb begin
    logic [PosBits-1:0] p, p1;
    logic               take, ext, fl;
    kind_t              k, pk;
    tok_t               t;
    scan_mode_next       = scan_mode;
    token_start_next     = token_start;
    word_length_next     = word_length;
    held_first_byte_next = held_first_byte;
    escape_pending_next  = escape_pending;
    pfx_wr  = 1'b0;
    pfx_idx = word_length;
    n_res   = '0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    p  = byte_position;
    p1 = p + 1'b1;
    take = 1'b0;
    ext  = 1'b0;
    fl   = 1'b0;
    case (scan_mode)
      M_OP:      pk = (op_single(held_first_byte) == K_NONE) ? K_INVALID
                                                           : op_single(held_first_byte);
      M_WORD:    pk = word_kind(pfx_flat, word_length);
      M_ZERO, M_DEC: pk = K_INT;
      M_FRAC:    pk = K_REAL;
      M_EXPSIGN, M_EXPDIG: pk = K_SCI;
      M_BIN:     pk = K_BIN;
      M_OCT:     pk = K_OCT;
      M_HEX:     pk = K_HEX;
      M_STR:     pk = K_STR;
      default:   pk = K_CHAR;
    endcase
    t.kind  = '0;
    t.start = OffBits'(token_start);
    t.stop  = OffBits'(p1);
    t.last  = 1'b0;
    k = K_NONE;
    case (scan_mode)
      M_IDLE: ext = 1'b0;
      M_OP: begin
        k = op_pair(held_first_byte, source_byte);
        if (k != K_NONE) begin
          ext = 1'b1; t.kind = k; res[0] = t; n_res = 2'd1;
          scan_mode_next = M_IDLE;
        end else fl = 1'b1;
      end
      M_WORD: begin
        if (is_word(source_byte)) begin
          ext = 1'b1;
          pfx_wr = word_length < LenBits'(KwMaxLen);
          if (word_length <= LenBits'(KwMaxLen)) word_length_next = word_length + 1'b1;
        end else fl = 1'b1;
      end
      M_ZERO: begin
        take = 1'b1;
        if (source_byte == "b" || source_byte == "B") scan_mode_next = M_BIN;
        else if (source_byte == "o" || source_byte == "O") scan_mode_next = M_OCT;
        else if (source_byte == "x" || source_byte == "X") scan_mode_next = M_HEX;
        else if (is_digit(source_byte)) scan_mode_next = M_DEC;
        else if (source_byte == ".") scan_mode_next = M_FRAC;
        else take = 1'b0;
        ext = take; fl = !take;
      end
      M_DEC: begin
        if (is_digit(source_byte)) take = 1'b1;
        else if (source_byte == ".") begin scan_mode_next = M_FRAC; take = 1'b1; end
        ext = take; fl = !take;
      end
      M_FRAC: begin
        if (is_digit(source_byte)) take = 1'b1;
        else if (source_byte == "e" || source_byte == "E") begin
          scan_mode_next = M_EXPSIGN; take = 1'b1;
        end
        ext = take; fl = !take;
      end
      M_EXPSIGN: begin
        if (source_byte == "+" || source_byte == "-" || is_digit(source_byte)) begin
          scan_mode_next = M_EXPDIG; take = 1'b1;
        end
        ext = take; fl = !take;
      end
      M_EXPDIG: begin ext = is_digit(source_byte); fl = !ext; end
      M_BIN: begin ext = source_byte == "0" || source_byte == "1"; fl = !ext; end
      M_OCT: begin ext = source_byte >= "0" && source_byte <= "7"; fl = !ext; end
      M_HEX: begin ext = is_hex(source_byte); fl = !ext; end
      M_STR: begin
        ext = 1'b1;
        if (escape_pending) escape_pending_next = 1'b0;
        else if (source_byte == 8'h5c) escape_pending_next = 1'b1;
        else if (source_byte == "\"") begin
          t.kind = K_STR; res[0] = t; n_res = 2'd1; scan_mode_next = M_IDLE;
        end
      end
      M_CHOPEN: begin
        ext = 1'b1;
        scan_mode_next = (source_byte == 8'h5c) ? M_CHESC : M_CHCLOSE;
      end
      M_CHESC: begin ext = 1'b1; scan_mode_next = M_CHCLOSE; end
      default: begin
        if (source_byte == "'") begin
          ext = 1'b1; t.kind = K_CHAR; res[0] = t; n_res = 2'd1;
          scan_mode_next = M_IDLE;
        end else fl = 1'b1;
      end
    endcase
    if (fl) begin
      // pending token ends before this byte
      t.kind = pk; t.stop = OffBits'(p);
      res[0] = t; n_res = 2'd1;
      scan_mode_next = M_IDLE;
    end
    if (!ext) begin
      token_start_next    = p;
      escape_pending_next = 1'b0;
      t.start = OffBits'(p);
      t.stop  = OffBits'(p1);
      t.kind  = lone_kind(source_byte);
      if (is_space(source_byte)) begin
      end else if (t.kind != K_NONE) begin
        res[n_res] = t; n_res = n_res + 1'b1;
      end else if (op_single(source_byte) != K_NONE) begin
        held_first_byte_next = source_byte; scan_mode_next = M_OP;
      end else if (source_byte == "\"") begin
        scan_mode_next = M_STR;
      end else if (source_byte == "'") begin
        scan_mode_next = M_CHOPEN;
      end else if (is_alpha(source_byte) || source_byte == "_") begin
        pfx_wr = 1'b1; pfx_idx = '0;
        word_length_next = LenBits'(1); scan_mode_next = M_WORD;
      end else if (source_byte == "0") begin
        scan_mode_next = M_ZERO;
      end else if (is_digit(source_byte)) begin
        scan_mode_next = M_DEC;
      end else begin
        t.kind = K_INVALID; res[n_res] = t; n_res = n_res + 1'b1;
      end
    end
    if (final_byte) begin
      if (scan_mode_next != M_IDLE) begin
        // kind of whatever is still pending after this byte
        case (scan_mode_next)
          M_OP: pk = (op_single(held_first_byte_next) == K_NONE) ? K_INVALID
                                                              : op_single(held_first_byte_next);
          M_WORD: begin
            if (pfx_idx == '0 && !ext) pk = (source_byte == "_") ? K_ID
                          : word_kind({64'd0, source_byte}, LenBits'(1));
            else pk = word_kind(pfx_wr ? (pfx_flat & ~({{(KwMaxLen*8-8){1'b0}}, 8'hff}
                          << (8*int'(pfx_idx)))) | ({{(KwMaxLen*8-8){1'b0}}, source_byte}
                          << (8*int'(pfx_idx))) : pfx_flat, word_length_next);
          end
          M_ZERO, M_DEC: pk = K_INT;
          M_FRAC:    pk = K_REAL;
          M_EXPSIGN, M_EXPDIG: pk = K_SCI;
          M_BIN:     pk = K_BIN;
          M_OCT:     pk = K_OCT;
          M_HEX:     pk = K_HEX;
          M_STR:     pk = K_STR;
          default:   pk = K_CHAR;
        endcase
        t.kind  = pk;
        t.start = OffBits'(token_start_next);
        t.stop  = OffBits'(p1);
        t.last  = 1'b0;
        res[n_res] = t; n_res = n_res + 1'b1;
      end
      t.kind = K_EOF; t.start = OffBits'(p1); t.stop = OffBits'(p1); t.last = 1'b1;
      res[n_res] = t; n_res = n_res + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= M_IDLE;
      byte_position   <= '0;
      token_start     <= '0;
      word_length     <= '0;
      held_first_byte <= '0;
      escape_pending  <= 1'b0;
    end else if (in_xfer) begin
      if (final_byte) begin
        scan_mode       <= M_IDLE;
        byte_position   <= '0;
        token_start     <= '0;
        word_length     <= '0;
        held_first_byte <= '0;
        escape_pending  <= 1'b0;
      end else begin
        scan_mode       <= scan_mode_next;
        byte_position   <= byte_position + 1'b1;
        token_start     <= token_start_next;
        word_length     <= word_length_next;
        held_first_byte <= held_first_byte_next;
        escape_pending  <= escape_pending_next;
      end
    end
  end

  // prefix bytes: payload only, never read before written
  always_ff @(posedge clk) begin
    if (in_xfer && pfx_wr && !final_byte) begin
      word_prefix[pfx_idx] <= source_byte;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_res) q_mem[wr_ptr + QIdx'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (in_xfer) wr_ptr <= wr_ptr + QIdx'(n_res);
      if (out_xfer) rd_ptr <= rd_ptr + 1'b1;
      q_count <= q_count + (in_xfer ? (QIdx+1)'(n_res) : '0) - (QIdx+1)'(out_xfer);
    end
  end

  assign token_kind   = q_mem[rd_ptr].kind;
  assign start_offset = q_mem[rd_ptr].start;
  assign end_offset   = q_mem[rd_ptr].stop;
  assign end_of_run   = q_mem[rd_ptr].last;

`ifndef SYNTHESIS
  a_qbound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QIdx+1)'(QDepth)) else $error("result queue overflow");
  a_fin_eof: assert property (@(posedge clk) disable iff (rst)
    in_xfer && final_byte |=> q_count != '0) else $error("final byte gave no result");
  a_fin_rst: assert property (@(posedge clk) disable iff (rst)
    in_xfer && final_byte |=> byte_position == '0 && scan_mode == M_IDLE)
    else $error("state not cleared after final byte");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    q_count > (QIdx+1)'(1) |-> in_stall) else $error("accepting without queue room");
`endif

endmodule

[tb/tb.sv]
// Testbench for the source byte tokenizer: random and directed byte streams against a predictor.
`timescale 1ns / 1ps
module tb;
  import sbt_pkg::*;

  // Token as seen on the output side
  typedef struct {
    logic [6:0]  kind;
    logic [31:0] start;
    logic [31:0] stop;
    logic        last;
  } token_rec_t;

  // Scoreboard: a lexer predictor and a queue of tokens still owed by the block
  class token_scoreboard;
    mode_t       mode;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [7:0]  prefix [KwMaxLen];
    int          word_len;
    logic [7:0]  held;
    logic        esc;
    token_rec_t  owed [$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = M_IDLE; pos = 0; tok_start = 0; word_len = 0; held = 0; esc = 0;
      foreach (prefix[i]) prefix[i] = 0;
    endfunction

    function void owe(logic [6:0] k, logic [31:0] s, logic [31:0] e, logic l);
      token_rec_t t;
      t.kind = k; t.start = s; t.stop = e; t.last = l;
      owed.push_back(t);
    endfunction

    function logic digit(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
    function logic alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function logic hexd(logic [7:0] b);
      return digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function int lone(logic [7:0] b);
      case (b)
        ".": return 12; ":": return 13; ";": return 37; ",": return 35;
        "(": return 31; ")": return 32; "{": return 33; "}": return 34;
        "[": return 29; "]": return 30; "~": return 23; "|": return 24;
        "#": return 25; "?": return 26; 8'h5c: return 27; "&": return 28;
        "^": return 38; "$": return 39; "@": return 40;
        default: return -1;
      endcase
    endfunction

    function int single_op(logic [7:0] b);
      case (b)
        "+": return 0; "-": return 9; "*": return 14; "/": return 16;
        "%": return 18; "<": return 3; ">": return 5; "=": return 20;
        "!": return 7;
        default: return -1;
      endcase
    endfunction

    function int pair_op(logic [7:0] a, logic [7:0] b);
      if (a == "+") return b == "=" ? 1 : (b == "+" ? 2 : -1);
      if (a == "-") return b == ">" ? 10 : (b == "=" ? 11 : -1);
      if (a == "=") return b == ">" ? 21 : (b == "=" ? 22 : -1);
      if (b != "=") return -1;
      case (a)
        "*": return 15; "/": return 17; "%": return 19;
        "<": return 4; ">": return 6; "!": return 8;
        default: return -1;
      endcase
    endfunction

    // Keyword match on the held prefix
    function logic [6:0] keyword_kind();
      string kw [39] = '{"and", "as", "bool", "break", "catch", "const", "continue",
        "else", "enum", "error", "extern", "false", "fn", "for", "if", "in", "inline",
        "is", "let", "match", "mod", "newtype", "not", "null", "or", "private", "ref",
        "return", "self", "Self", "static", "struct", "test", "true", "typealias",
        "union", "use", "when", "while"};
      int codes [39] = '{42, 43, 44, 45, 46, 49, 50, 51, 52, 54, 55, 56, 57, 58, 60,
        61, 62, 68, 69, 70, 71, 72, 73, 74, 75, 76, 79, 80, 82, 81, 84, 86, 87, 88,
        89, 90, 91, 92, 93};
      logic same;
      if (word_len > KwMaxLen) return K_ID;
      for (int i = 0; i < 39; i++) begin
        if (kw[i].len() == word_len) begin
          same = 1;
          for (int j = 0; j < word_len; j++)
            if (kw[i][j] != prefix[j]) same = 0;
          if (same) return codes[i][6:0];
        end
      end
      return K_ID;
    endfunction

    function logic [6:0] pending();
      int k;
      case (mode)
        M_OP: begin
          k = single_op(held);
          return k < 0 ? K_INVALID : k[6:0];
        end
        M_WORD: return keyword_kind();
        M_ZERO, M_DEC: return K_INT;
        M_FRAC: return K_REAL;
        M_EXPSIGN, M_EXPDIG: return K_SCI;
        M_BIN: return K_BIN;
        M_OCT: return K_OCT;
        M_HEX: return K_HEX;
        M_STR: return K_STR;
        default: return K_CHAR;
      endcase
    endfunction

    // Returns 1 when the byte joins the token in progress
    function logic extend(logic [7:0] b, logic [31:0] p);
      logic take;
      int k;
      take = 0;
      case (mode)
        M_IDLE: return 0;
        M_OP: begin
          k = pair_op(held, b);
          if (k >= 0) begin
            owe(k[6:0], tok_start, p + 1, 0); mode = M_IDLE; return 1;
          end
        end
        M_WORD: if (alpha(b) || digit(b) || b == "_") begin
          if (word_len < KwMaxLen) prefix[word_len] = b;
          if (word_len <= KwMaxLen) word_len++;
          return 1;
        end
        M_ZERO: begin
          take = 1;
          if (b == "b" || b == "B") mode = M_BIN;
          else if (b == "o" || b == "O") mode = M_OCT;
          else if (b == "x" || b == "X") mode = M_HEX;
          else if (digit(b)) mode = M_DEC;
          else if (b == ".") mode = M_FRAC;
          else take = 0;
        end
        M_DEC: if (digit(b)) take = 1;
               else if (b == ".") begin mode = M_FRAC; take = 1; end
        M_FRAC: if (digit(b)) take = 1;
                else if (b == "e" || b == "E") begin mode = M_EXPSIGN; take = 1; end
        M_EXPSIGN: if (b == "+" || b == "-" || digit(b)) begin
          mode = M_EXPDIG; take = 1;
        end
        M_EXPDIG: take = digit(b);
        M_BIN: take = (b == "0" || b == "1");
        M_OCT: take = (b >= "0" && b <= "7");
        M_HEX: take = hexd(b);
        M_STR: begin
          if (esc) esc = 0;
          else if (b == 8'h5c) esc = 1;
          else if (b == "\"") begin owe(K_STR, tok_start, p + 1, 0); mode = M_IDLE; end
          return 1;
        end
        M_CHOPEN: begin mode = (b == 8'h5c) ? M_CHESC : M_CHCLOSE; return 1; end
        M_CHESC: begin mode = M_CHCLOSE; return 1; end
        default: if (b == "'") begin
          owe(K_CHAR, tok_start, p + 1, 0); mode = M_IDLE; return 1;
        end
      endcase
      if (take) return 1;
      owe(pending(), tok_start, p, 0);
      mode = M_IDLE;
      return 0;
    endfunction

    function void begin_token(logic [7:0] b, logic [31:0] p);
      int k;
      k = lone(b);
      tok_start = p; esc = 0;
      if (b == " " || (b >= 9 && b <= 13)) return;
      if (k >= 0) owe(k[6:0], p, p + 1, 0);
      else if (single_op(b) >= 0) begin held = b; mode = M_OP; end
      else if (b == "\"") mode = M_STR;
      else if (b == "'") mode = M_CHOPEN;
      else if (alpha(b) || b == "_") begin
        prefix[0] = b; word_len = 1; mode = M_WORD;
      end
      else if (b == "0") mode = M_ZERO;
      else if (digit(b)) mode = M_DEC;
      else owe(K_INVALID, p, p + 1, 0);
    endfunction

    // Note an accepted input byte
    function void note_byte(logic [7:0] b, logic fin);
      logic [31:0] p;
      p = pos;
      if (!extend(b, p)) begin_token(b, p);
      pos = p + 1;
      if (fin) begin
        if (mode != M_IDLE) owe(pending(), tok_start, pos, 0);
        owe(K_EOF, pos, pos, 1);
        clear();
      end
    endfunction

    // Check one accepted token against the oldest owed one
    function void check_token(logic [6:0] k, logic [31:0] s, logic [31:0] e, logic l);
      token_rec_t t;
      if (owed.size() == 0) begin
        $display("%0t: unexpected token kind %0d start %0d end %0d", $time, k, s, e);
        errors++;
        return;
      end
      t = owed.pop_front();
      if (k !== t.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, t.kind, k); errors++;
      end
      if (s !== t.start) begin
        $display("%0t: start expected %0d actual %0d", $time, t.start, s); errors++;
      end
      if (e !== t.stop) begin
        $display("%0t: end expected %0d actual %0d", $time, t.stop, e); errors++;
      end
      if (l !== t.last) begin
        $display("%0t: end_of_run expected %0b actual %0b", $time, t.last, l); errors++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  source_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] end_offset;
  logic        end_of_run;

  token_scoreboard board;
  int          cycles;
  int          burst_left;
  int          stall_mode;

  source_byte_tokenizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_byte  (source_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .end_of_run   (end_of_run)
  );

  // low first, so the first rising edge comes after the initial set-up
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Output side: check each token transfer, then pick the next stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_token(token_kind, start_offset, end_offset, end_of_run);
      // stall pattern changes every so often: none, light, heavy
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one byte and hold it until the transfer; gaps come between bursts
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    source_byte <= b;
    final_byte  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, fin);
  endtask

  task automatic send_text(input string s, input logic fin_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fin_at_end && (i == s.len() - 1));
  endtask

  // Random fragment: keywords, words, numbers, literals, operators, punctuation, white space or noise
  function automatic string random_fragment();
    string kws [12] = '{"and", "typealias", "Self", "self", "continue", "while",
      "newtype", "private", "return", "fn", "in", "inline"};
    string ops [16] = '{"+", "+=", "++", "-", "->", "-=", "=", "=>", "==", "<=",
      ">=", "!=", "*=", "/=", "%=", "!"};
    string digs = "0123456789abcdefABCDEF_xyzXYZ";
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 9))
      0: s = kws[$urandom_range(0, 11)];
      1: begin
        n = $urandom_range(1, 14);
        s = "w";
        repeat (n) s = {s, string'(digs[$urandom_range(0, digs.len() - 1)])};
      end
      2: begin
        s = "0";
        case ($urandom_range(0, 3))
          0: s = {s, "b101"};
          1: s = {s, "o777"};
          2: s = {s, "xDeadBeef"};
          default: s = {s, "7.25e-3"};
        endcase
      end
      3: s = $urandom_range(0, 1) ? "123.45E+6" : "98.6";
      4: s = $urandom_range(0, 1) ? "\"ab\\\"c\"" : "\"\\\\\"";
      5: s = $urandom_range(0, 1) ? "'x'" : "'\\n'";
      6: s = ops[$urandom_range(0, 15)];
      7: s = ";(){}[],.:~|#?\\&^$@";
      8: s = $urandom_range(0, 1) ? "\t\n\r\v\f" : "  ";
      default: begin
        // noise byte, any nonzero value
        s = " ";
        s[0] = $urandom_range(1, 255);
      end
    endcase
    return s;
  endfunction

  initial begin
    string frag;
    int sent;
    board       = new();
    cycles      = 0;
    burst_left  = 0;
    stall_mode  = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    source_byte = 8'h00;
    final_byte  = 1'b0;
    out_stall   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: words, operators, numbers of each base, literals, extremes of the byte, cut literals
    send_text("and _ abcdefghijk", 0);
    send_text(" +=++->-=*=/=%=<=>=!==>==", 0);
    send_text("+;", 0);
    send_byte(8'hff, 0);
    send_byte(8'h00, 0);
    send_byte(8'h80, 0);
    send_text("0b1 0o7 0x1f 0 1.5e+3 2.0E9", 0);
    send_text("'\\'''a'", 0);
    send_text("\"abc", 1);
    send_text("'\\", 1);
    send_text("x", 1);

    // Hold off until everything owed has arrived
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);

    // Random: mostly well-formed fragments, sources of random length
    sent = 0;
    while (sent < 480) begin
      frag = random_fragment();
      if ($urandom_range(0, 2) == 0) frag = {frag, " "};
      for (int i = 0; i < frag.len(); i++) begin
        send_byte(frag[i], (i == frag.len() - 1) && ($urandom_range(0, 15) == 0));
        sent++;
      end
    end
    send_byte(8'h0a, 1'b1);
    in_valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
